@@ rtl/core/i2c_master_byte_engine_assert.svh @@
// Assertion macros shared by the I2C master byte engine modules.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define I2CM_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define I2CM_ASSERT(lbl, prop, msg)
`define I2CM_NEVER(lbl, expr, msg)
`endif
`endif

@@ rtl/core/i2cm_pkg.sv @@
// Package with the shared types and constants of the I2C master byte engine.
`timescale 1ns / 1ps
package i2cm_pkg;

    localparam int DELAY_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int BITS_PER_BYTE   = 8;

    localparam int HALF_WIDTH  = 16;
    localparam int LIMIT_WIDTH = 8;
    localparam int CFG_WIDTH   = 16;

    localparam logic [HALF_WIDTH-1:0]  HALF_PERIOD_RST = 16'd16;
    localparam logic [LIMIT_WIDTH-1:0] ACK_LIMIT_RST   = 8'd255;

    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_LIMIT   = 1'b1;

    localparam int IN_TDATA_WIDTH  = 16;
    localparam int OUT_TDATA_WIDTH = 16;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_ST_D,
        PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D,
        PH_WR_LOW, PH_WR_DATA, PH_WR_HIGH, PH_WR_REL, PH_WR_ACKHI, PH_WR_POLL, PH_WR_TAIL,
        PH_RD_LOW, PH_RD_HIGH, PH_RD_WAIT, PH_RD_END,
        PH_RD_ACK0, PH_RD_ACK1, PH_RD_ACK2, PH_RD_ACK3
    } t_phase;

    // One queued tick: decoded command plus the fields that travel with it.
    typedef struct packed {
        logic       sda_in;
        logic       final_nack;
        logic [7:0] write_byte;
        t_op        op;
    } t_cmd;

    // One result word, scl_level in bit 0.
    typedef struct packed {
        logic       bus_owned;
        logic       ack_received;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_released;
        logic       sda_level;
        logic       scl_level;
    } t_res;

endpackage

@@ rtl/core/i2c_master_byte_engine.sv @@
// Top level of the I2C master byte engine: decoder, tick queue and bus engine.
// Throughput: one tick word per cycle while the result output is not stalled.
// Each result word is registered when the engine pops its tick word from the queue.
// The tick queue lets input words keep arriving while a result waits on the output.
// Reset (synchronous, active low) empties the queue, idles the engine, drives SCL and
// SDA high, and loads half_period_ticks with 16 and ack_poll_limit with 255.
`timescale 1ns / 1ps
module i2c_master_byte_engine #(
    parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF,
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_idx,
    input  logic [i2cm_pkg::CFG_WIDTH-1:0]       i_cfg_data,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // operation[2:0], write_byte[10:3], final_nack[11], sda_in[12], zero fill
    input  logic [i2cm_pkg::IN_TDATA_WIDTH-1:0]  i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // scl_level[0], sda_level[1], sda_released[2], busy_res[3], done_res[4],
    // read_byte[12:5], ack_received[13], bus_owned[14], zero fill
    output logic [i2cm_pkg::OUT_TDATA_WIDTH-1:0] o_m_axis_tdata
);

    logic           w_push, w_full, w_pop, w_valid;
    i2cm_pkg::t_cmd w_cmd_in, w_cmd_out;
    i2cm_pkg::t_res w_res;

    // The front end only decodes; a tick word waits here only while the queue is full.
    i2cm_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_cmd           (w_cmd_in)
    );

    // The queue absorbs words while the output side stalls.
    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_valid),
        .o_data  (w_cmd_out)
    );

    // The engine advances its sequencer once per popped word and registers the result.
    i2cm_engine #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_valid),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (w_res)
    );

    assign o_m_axis_tdata = {1'b0, w_res};

endmodule

@@ rtl/core/i2cm_front.sv @@
// Input side: takes tick words from the stream and decodes them into queue entries.
`timescale 1ns / 1ps
module i2cm_front (
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [i2cm_pkg::IN_TDATA_WIDTH-1:0] i_s_axis_tdata,
    input  logic                                i_full,
    output logic                                o_push,
    output i2cm_pkg::t_cmd                      o_cmd
);

    assign o_s_axis_tready = !i_full;
    assign o_push          = i_s_axis_tvalid && !i_full;

    // Codes above read byte carry no command and run as an idle tick.
    always_comb begin
        case (i_s_axis_tdata[2:0])
            3'd1:    o_cmd.op = i2cm_pkg::OP_START;
            3'd2:    o_cmd.op = i2cm_pkg::OP_STOP;
            3'd3:    o_cmd.op = i2cm_pkg::OP_WRITE;
            3'd4:    o_cmd.op = i2cm_pkg::OP_READ;
            default: o_cmd.op = i2cm_pkg::OP_NONE;
        endcase
        o_cmd.write_byte = i_s_axis_tdata[10:3];
        o_cmd.final_nack = i_s_axis_tdata[11];
        o_cmd.sda_in     = i_s_axis_tdata[12];
    end

endmodule

@@ rtl/core/i2cm_queue.sv @@
// Short first-word-fallthrough queue between the decoder and the bus engine.
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_assert.svh"
module i2cm_queue #(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  i2cm_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output i2cm_pkg::t_cmd o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    i2cm_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `I2CM_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "queue count above depth")
    `I2CM_NEVER(a_pop_empty, i_pop && (r_count == '0), "pop from empty queue")
    `I2CM_NEVER(a_push_full, i_push && o_full, "push into full queue")

endmodule

@@ rtl/core/i2cm_engine.sv @@
// Bus engine: SCL/SDA sequencer; one tick per cycle when not stalled; result registered.
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_assert.svh"
module i2cm_engine #(
    parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [i2cm_pkg::CFG_WIDTH-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  i2cm_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output i2cm_pkg::t_res                 o_res
);

    localparam logic [32:0] DMAX = (33'd1 << DELAY_WIDTH) - 33'd1;
    localparam int          BPB  = i2cm_pkg::BITS_PER_BYTE;

    logic [i2cm_pkg::HALF_WIDTH-1:0]  r_half;
    logic [i2cm_pkg::LIMIT_WIDTH-1:0] r_limit;

    i2cm_pkg::t_phase r_phase, n_phase;
    logic [3:0]             r_bit, n_bit;
    logic [BPB-1:0]         r_shift, n_shift;
    logic [DELAY_WIDTH-1:0] r_delay, n_delay;
    logic [7:0]             r_poll, n_poll;
    logic                   r_nack, n_nack;
    logic                   r_ack, n_ack;
    logic                   r_scl, n_scl;
    logic                   r_sda, n_sda;
    logic                   r_rel, n_rel;
    logic                   r_owned, n_owned;
    logic [BPB-1:0]         r_rdata, n_rdata;
    logic                   n_done;
    logic                   r_out_valid;
    i2cm_pkg::t_res         r_out;

    logic [32:0]            w_h;
    logic [DELAY_WIDTH-1:0] w_reload;
    logic [7:0]             w_lim, w_poll_base, w_poll_next;
    logic                   w_poll_end;

    assign o_pop       = i_valid && (!r_out_valid || i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Hold length: zero acts as one, and it saturates to the counter range.
    always_comb begin
        w_h = {17'd0, r_half};
        if (r_half == '0) begin
            w_h = 33'd1;
        end
        if (w_h > DMAX) begin
            w_h = DMAX;
        end
        w_reload = DELAY_WIDTH'(w_h - 33'd1);
    end

    // Acknowledge poll: the first sample comes from the end of the SCL-high hold.
    always_comb begin
        w_lim       = (r_limit == '0) ? 8'd1 : r_limit;
        w_poll_base = (r_phase == i2cm_pkg::PH_WR_POLL) ? r_poll : 8'd0;
        w_poll_next = w_poll_base + 8'd1;
        w_poll_end  = !i_cmd.sda_in || (w_poll_next >= w_lim);
    end

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_delay = r_delay;
        n_poll  = r_poll;
        n_nack  = r_nack;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_rel   = r_rel;
        n_owned = r_owned;
        n_rdata = r_rdata;
        n_done  = 1'b0;
        if (r_phase == i2cm_pkg::PH_IDLE) begin
            case (i_cmd.op)
                i2cm_pkg::OP_START: begin
                    n_owned = 1'b1;
                    n_rel   = 1'b0;
                    n_sda   = 1'b1;
                    n_delay = w_reload;
                    n_phase = i2cm_pkg::PH_ST_A;
                end
                i2cm_pkg::OP_STOP: begin
                    n_rel   = 1'b0;
                    n_sda   = 1'b0;
                    n_delay = w_reload;
                    n_phase = i2cm_pkg::PH_SP_A;
                end
                i2cm_pkg::OP_WRITE: begin
                    n_shift = i_cmd.write_byte;
                    n_bit   = 4'd0;
                    n_ack   = 1'b0;
                    n_scl   = 1'b0;
                    n_delay = w_reload;
                    n_phase = i2cm_pkg::PH_WR_LOW;
                end
                i2cm_pkg::OP_READ: begin
                    n_nack  = i_cmd.final_nack;
                    n_shift = '0;
                    n_bit   = 4'd0;
                    n_rel   = 1'b1;
                    n_scl   = 1'b0;
                    n_delay = w_reload;
                    n_phase = i2cm_pkg::PH_RD_LOW;
                end
                default: ;
            endcase
        end else if (r_phase != i2cm_pkg::PH_WR_POLL && r_delay != '0) begin
            n_delay = r_delay - DELAY_WIDTH'(1);
        end else begin
            case (r_phase)
                i2cm_pkg::PH_ST_A: begin
                    n_scl = 1'b1; n_delay = w_reload; n_phase = i2cm_pkg::PH_ST_B;
                end
                i2cm_pkg::PH_ST_B: begin
                    n_sda = 1'b0; n_delay = w_reload; n_phase = i2cm_pkg::PH_ST_C;
                end
                i2cm_pkg::PH_ST_C: begin
                    n_scl = 1'b0; n_delay = w_reload; n_phase = i2cm_pkg::PH_ST_D;
                end
                i2cm_pkg::PH_SP_A: begin
                    n_scl = 1'b0; n_delay = w_reload; n_phase = i2cm_pkg::PH_SP_B;
                end
                i2cm_pkg::PH_SP_B: begin
                    n_scl = 1'b1; n_delay = w_reload; n_phase = i2cm_pkg::PH_SP_C;
                end
                i2cm_pkg::PH_SP_C: begin
                    n_sda = 1'b1; n_delay = w_reload; n_phase = i2cm_pkg::PH_SP_D;
                end
                i2cm_pkg::PH_ST_D: begin
                    n_phase = i2cm_pkg::PH_IDLE; n_delay = '0; n_done = 1'b1;
                end
                i2cm_pkg::PH_SP_D: begin
                    n_owned = 1'b0;
                    n_phase = i2cm_pkg::PH_IDLE; n_delay = '0; n_done = 1'b1;
                end
                i2cm_pkg::PH_WR_LOW: begin
                    if (r_bit < 4'(BPB)) begin
                        n_sda   = r_shift[BPB-1];
                        n_shift = {r_shift[BPB-2:0], 1'b0};
                        n_phase = i2cm_pkg::PH_WR_DATA;
                    end else begin
                        n_rel   = 1'b1;
                        n_sda   = 1'b1;
                        n_phase = i2cm_pkg::PH_WR_REL;
                    end
                    n_delay = w_reload;
                end
                i2cm_pkg::PH_WR_DATA: begin
                    n_scl = 1'b1; n_delay = w_reload; n_phase = i2cm_pkg::PH_WR_HIGH;
                end
                i2cm_pkg::PH_WR_HIGH: begin
                    n_scl   = 1'b0;
                    n_bit   = r_bit + 4'd1;
                    n_delay = w_reload;
                    n_phase = i2cm_pkg::PH_WR_LOW;
                end
                i2cm_pkg::PH_WR_REL: begin
                    n_scl = 1'b1; n_delay = w_reload; n_phase = i2cm_pkg::PH_WR_ACKHI;
                end
                i2cm_pkg::PH_WR_ACKHI, i2cm_pkg::PH_WR_POLL: begin
                    n_phase = i2cm_pkg::PH_WR_POLL;
                    if (!i_cmd.sda_in) begin
                        n_ack  = 1'b1;
                        n_poll = w_poll_base;
                    end else begin
                        n_poll = w_poll_next;
                    end
                    if (w_poll_end) begin
                        n_scl   = 1'b0;
                        n_delay = w_reload;
                        n_phase = i2cm_pkg::PH_WR_TAIL;
                    end
                end
                i2cm_pkg::PH_WR_TAIL: begin
                    n_rel   = 1'b0;
                    n_sda   = 1'b1;
                    n_phase = i2cm_pkg::PH_IDLE; n_delay = '0; n_done = 1'b1;
                end
                i2cm_pkg::PH_RD_LOW: begin
                    n_scl = 1'b1; n_delay = w_reload; n_phase = i2cm_pkg::PH_RD_HIGH;
                end
                i2cm_pkg::PH_RD_HIGH: begin
                    n_delay = w_reload; n_phase = i2cm_pkg::PH_RD_WAIT;
                end
                i2cm_pkg::PH_RD_WAIT: begin
                    n_shift = {r_shift[BPB-2:0], i_cmd.sda_in};
                    n_scl   = 1'b0;
                    n_bit   = r_bit + 4'd1;
                    n_delay = w_reload;
                    n_phase = i2cm_pkg::PH_RD_END;
                end
                i2cm_pkg::PH_RD_END: begin
                    n_scl   = 1'b0;
                    n_delay = w_reload;
                    if (r_bit < 4'(BPB)) begin
                        n_phase = i2cm_pkg::PH_RD_LOW;
                    end else begin
                        n_rel   = 1'b0;
                        n_phase = i2cm_pkg::PH_RD_ACK0;
                    end
                end
                i2cm_pkg::PH_RD_ACK0: begin
                    n_sda = r_nack; n_delay = w_reload; n_phase = i2cm_pkg::PH_RD_ACK1;
                end
                i2cm_pkg::PH_RD_ACK1: begin
                    n_scl = 1'b1; n_delay = w_reload; n_phase = i2cm_pkg::PH_RD_ACK2;
                end
                i2cm_pkg::PH_RD_ACK2: begin
                    n_scl = 1'b0; n_delay = w_reload; n_phase = i2cm_pkg::PH_RD_ACK3;
                end
                i2cm_pkg::PH_RD_ACK3: begin
                    n_rdata = r_shift;
                    n_phase = i2cm_pkg::PH_IDLE; n_delay = '0; n_done = 1'b1;
                end
                default: n_phase = i2cm_pkg::PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= i2cm_pkg::HALF_PERIOD_RST;
            r_limit <= i2cm_pkg::ACK_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2cm_pkg::CFG_HALF_PERIOD: r_half  <= i_cfg_data;
                i2cm_pkg::CFG_ACK_LIMIT:   r_limit <= i_cfg_data[i2cm_pkg::LIMIT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cm_pkg::PH_IDLE;
            r_bit       <= '0;
            r_shift     <= '0;
            r_delay     <= '0;
            r_poll      <= '0;
            r_nack      <= 1'b0;
            r_ack       <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_rel       <= 1'b0;
            r_owned     <= 1'b0;
            r_rdata     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_delay     <= n_delay;
                r_poll      <= n_poll;
                r_nack      <= n_nack;
                r_ack       <= n_ack;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_rel       <= n_rel;
                r_owned     <= n_owned;
                r_rdata     <= n_rdata;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.scl_level    <= n_scl;
            r_out.sda_level    <= n_sda;
            r_out.sda_released <= n_rel;
            r_out.busy_res     <= (n_phase != i2cm_pkg::PH_IDLE);
            r_out.done_res     <= n_done;
            r_out.read_byte    <= n_rdata;
            r_out.ack_received <= n_ack;
            r_out.bus_owned    <= n_owned;
        end
    end

    `I2CM_NEVER(a_done_busy, r_out_valid && r_out.done_res && r_out.busy_res, "done while busy")
    `I2CM_ASSERT(a_idle_delay, (r_phase == i2cm_pkg::PH_IDLE) |-> (r_delay == '0), "idle hold left")
    `I2CM_ASSERT(a_poll_pins, (r_phase == i2cm_pkg::PH_WR_POLL) |-> (r_rel && r_scl), "poll pins")

endmodule
